// ===== hdl/ujae_pkg.sv =====
package ujae_pkg;

    // Datapath widths: CORDIC x/y working registers and the angle accumulator.
    localparam int XW = 34;
    localparam int ZW = 28;

    // Number of entries in the arctangent table.
    localparam int TABLE_LEN = 24;

    // Angles in the accumulator are in units of 2^-24 radian.
    localparam logic signed [ZW-1:0] PI_UNITS = 28'sd52707179;

    // Largest output angle magnitude in Q3.13.
    localparam logic signed [17:0] ANGLE_MAX = 18'sd25736;

    // Rounding offset applied before the final shift to Q3.13.
    localparam logic signed [ZW:0] ROUND_HALF = 29'sd1024;

    // Register addresses, decoded from the word address bit.
    localparam logic REG_LENGTH_TOL = 1'b0;
    localparam logic REG_ANGLE_TOL  = 1'b1;

    // atan(2^-i) rounded to units of 2^-24 radian.
    localparam logic signed [ZW-1:0] ATAN_TABLE [TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

endpackage

// ===== hdl/universal_joint_angle_extract_unit.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    five Q1.14 rotation entries, three Q16.16 shifts
// m_        out        m_valid / m_ready    two Q3.13 angles, imprecise flag
// APB       in         psel/penable/pready  length_tolerance (0x0), angle_tolerance (0x4)
//
// One input stage for quadrant folding and tolerance checks, one register per
// CORDIC step and one output stage for rounding and saturation. One item is
// accepted every cycle while the output is not stalled.
// Reset is synchronous and active low; it clears all valid bits and loads the
// tolerance registers with their defaults. Each stage holds its item while the
// stage after it is full and cannot load, so bubbles are squeezed out and a
// stalled output still lets earlier stages fill.
module universal_joint_angle_extract_unit
    import ujae_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_rot_row0_col2,
    input  logic signed [15:0] s_rot_row1_col2,
    input  logic signed [15:0] s_rot_row2_col0,
    input  logic signed [15:0] s_rot_row2_col1,
    input  logic signed [15:0] s_rot_row2_col2,
    input  logic signed [31:0] s_shift_x,
    input  logic signed [31:0] s_shift_y,
    input  logic signed [31:0] s_shift_z,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_first_angle,
    output logic signed [15:0] m_second_angle,
    output logic               m_imprecise,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Configuration registers.
    logic [30:0] length_tol_reg;
    logic [14:0] angle_tol_reg;

    // Pipeline registers: index k holds an item after k CORDIC steps.
    logic [STEPS:0]          valid_reg;
    logic                    flag_reg [STEPS+1];
    logic signed [XW-1:0]    x_reg    [2][STEPS+1];
    logic signed [XW-1:0]    y_reg    [2][STEPS+1];
    logic signed [ZW-1:0]    z_reg    [2][STEPS+1];

    // Output register.
    logic                    m_valid_reg;
    logic signed [15:0]      angle_reg [2];
    logic                    imprecise_reg;

    // load_w[k]: stage k takes a new item (or bubble) this cycle.
    logic [STEPS+1:0]        load_w;

    // Input stage operands.
    logic signed [16:0]      op_x [2];
    logic signed [16:0]      op_y [2];
    logic signed [16:0]      fold_x [2];
    logic signed [16:0]      fold_y [2];
    logic signed [ZW-1:0]    fold_z [2];
    logic                    flag_next;

    // Output stage rounding.
    logic signed [ZW:0]      round_sum [2];
    logic signed [17:0]      round_val [2];
    logic signed [17:0]      sat_val   [2];

    logic                    cfg_write;

    // Magnitude of a signed word compared against the length tolerance.
    function automatic logic over_length(input logic signed [31:0] v,
                                         input logic [30:0] tol);
        logic [32:0] v_ext;
        logic [32:0] v_abs;
        begin
            v_ext = {v[31], v};
            v_abs = v[31] ? (33'd0 - v_ext) : v_ext;
            over_length = v_abs > {2'b00, tol};
        end
    endfunction

    // Configuration port: writes complete in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_tol_reg <= 31'd66;
            angle_tol_reg  <= 15'd16;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LENGTH_TOL: length_tol_reg <= pwdata[30:0];
                REG_ANGLE_TOL:  angle_tol_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LENGTH_TOL: prdata = {1'b0, length_tol_reg};
            REG_ANGLE_TOL:  prdata = {17'd0, angle_tol_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Stall chain: a stage loads when it is empty or its successor loads.
    assign load_w[STEPS+1] = !m_valid_reg || m_ready;

    for (genvar k = 0; k <= STEPS; k++) begin : g_load
        assign load_w[k] = !valid_reg[k] || load_w[k+1];
    end

    assign s_ready = load_w[0];

    // Valid bits move with their items.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_w[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k <= STEPS; k++) begin
                if (load_w[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (load_w[STEPS+1]) begin
                m_valid_reg <= valid_reg[STEPS];
            end
        end
    end

    // Operands of the two arctangents; the first uses the negated m12 as x.
    assign op_y[0] = {s_rot_row0_col2[15], s_rot_row0_col2};
    assign op_x[0] = -{s_rot_row1_col2[15], s_rot_row1_col2};
    assign op_y[1] = {s_rot_row2_col0[15], s_rot_row2_col0};
    assign op_x[1] = {s_rot_row2_col1[15], s_rot_row2_col1};

    // Fold a vector with negative x into the right half plane, offset by pi.
    for (genvar a = 0; a < 2; a++) begin : g_fold
        always_comb begin
            if (op_x[a] < 0) begin
                fold_x[a] = -op_x[a];
                fold_y[a] = -op_y[a];
                fold_z[a] = (op_y[a] >= 0) ? PI_UNITS : -PI_UNITS;
            end else begin
                fold_x[a] = op_x[a];
                fold_y[a] = op_y[a];
                fold_z[a] = '0;
            end
        end
    end

    // Tolerance checks on the translation column and on m22.
    always_comb begin
        logic [15:0] m22_abs;
        m22_abs = s_rot_row2_col2[15] ? (16'd0 - s_rot_row2_col2) : s_rot_row2_col2;
        flag_next = over_length(s_shift_x, length_tol_reg)
                 || over_length(s_shift_y, length_tol_reg)
                 || over_length(s_shift_z, length_tol_reg)
                 || ({1'b0, m22_abs} > {2'b00, angle_tol_reg});
    end

    // Input stage: the tolerance flag enters with the item.
    always_ff @(posedge aclk) begin
        if (load_w[0]) begin
            flag_reg[0] <= flag_next;
        end
    end

    // Input stage: scale operands by 2^14 into the working width.
    for (genvar a = 0; a < 2; a++) begin : g_input
        always_ff @(posedge aclk) begin
            if (load_w[0]) begin
                x_reg[a][0] <= {{(XW-31){fold_x[a][16]}}, fold_x[a], 14'd0};
                y_reg[a][0] <= {{(XW-31){fold_y[a][16]}}, fold_y[a], 14'd0};
                z_reg[a][0] <= fold_z[a];
            end
        end
    end

    // One registered CORDIC step per stage for each angle.
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (load_w[i+1]) begin
                flag_reg[i+1] <= flag_reg[i];
            end
        end

        for (genvar a = 0; a < 2; a++) begin : g_lane
            logic signed [XW-1:0] xs;
            logic signed [XW-1:0] ys;
            logic signed [XW-1:0] x_next;
            logic signed [XW-1:0] y_next;
            logic signed [ZW-1:0] z_next;

            assign xs = x_reg[a][i] >>> i;
            assign ys = y_reg[a][i] >>> i;

            // Positive y rotates clockwise, negative y counterclockwise, zero holds.
            always_comb begin
                x_next = x_reg[a][i];
                y_next = y_reg[a][i];
                z_next = z_reg[a][i];
                if (y_reg[a][i] > 0) begin
                    x_next = x_reg[a][i] + ys;
                    y_next = y_reg[a][i] - xs;
                    z_next = z_reg[a][i] + ATAN_TABLE[i];
                end else if (y_reg[a][i] < 0) begin
                    x_next = x_reg[a][i] - ys;
                    y_next = y_reg[a][i] + xs;
                    z_next = z_reg[a][i] - ATAN_TABLE[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (load_w[i+1]) begin
                    x_reg[a][i+1] <= x_next;
                    y_reg[a][i+1] <= y_next;
                    z_reg[a][i+1] <= z_next;
                end
            end
        end
    end

    // Round half up to Q3.13 and saturate to plus or minus pi.
    for (genvar a = 0; a < 2; a++) begin : g_round
        assign round_sum[a] = {z_reg[a][STEPS][ZW-1], z_reg[a][STEPS]} + ROUND_HALF;
        assign round_val[a] = 18'(round_sum[a] >>> 11);
        always_comb begin
            if (round_val[a] > ANGLE_MAX) begin
                sat_val[a] = ANGLE_MAX;
            end else if (round_val[a] < -ANGLE_MAX) begin
                sat_val[a] = -ANGLE_MAX;
            end else begin
                sat_val[a] = round_val[a];
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (load_w[STEPS+1]) begin
            angle_reg[0]  <= sat_val[0][15:0];
            angle_reg[1]  <= sat_val[1][15:0];
            imprecise_reg <= flag_reg[STEPS];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_first_angle  = angle_reg[0];
    assign m_second_angle = angle_reg[1];
    assign m_imprecise    = imprecise_reg;

    // An accepted item lands in the input stage.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted item did not enter the input stage");

    // A blocked input stage keeps its item and data.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[0] && !load_w[0]) |=> (valid_reg[0] && $stable(z_reg[0][0])))
        else $error("stalled input stage lost its item");

    // A new output item comes only from the last CORDIC stage.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(valid_reg[STEPS]))
        else $error("output became valid without an item in the last stage");

    // Delivered angles stay within plus or minus pi.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((angle_reg[0] <= 16'sd25736) && (angle_reg[0] >= -16'sd25736)
                      && (angle_reg[1] <= 16'sd25736) && (angle_reg[1] >= -16'sd25736)))
        else $error("output angle out of range");

endmodule
